@@ rtl/core/pcs_pkg.sv @@
// ----------------------------------------------------------------------------
// pcs_pkg: shared types and constants of the Panama core step unit
// Word and stage types, transaction payloads, op codes and the fixed
// permutation and rotation tables of the gamma/pi round.
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int CoreWords    = 17;
    localparam int StageWords   = 8;
    localparam int BufferStages = 32;

    // Fixed buffer taps, counted from the newest stage
    localparam int TapEarly  = 4;
    localparam int TapLate   = 16;
    localparam int TapMix    = 25;
    localparam int TapOldest = BufferStages - 1;

    // Op codes
    localparam logic [1:0] OpPush  = 2'd0;
    localparam logic [1:0] OpPull  = 2'd1;
    localparam logic [1:0] OpEmit  = 2'd2;
    localparam logic [1:0] OpClear = 2'd3;

    typedef logic [31:0] t_word;
    typedef t_word [CoreWords-1:0]  t_core;
    typedef t_word [StageWords-1:0] t_stage;

    typedef struct packed {
        logic [1:0] op;
        t_word      in_word0;
        t_word      in_word1;
        t_word      in_word2;
        t_word      in_word3;
        t_word      in_word4;
        t_word      in_word5;
        t_word      in_word6;
        t_word      in_word7;
    } t_in_item;

    typedef struct packed {
        t_word out_word0;
        t_word out_word1;
        t_word out_word2;
        t_word out_word3;
        t_word out_word4;
        t_word out_word5;
        t_word out_word6;
        t_word out_word7;
    } t_out_item;

    // Pi destination for each gamma word: 5*i mod 17
    localparam int PiIndex [CoreWords] = '{
        0, 5, 10, 15, 3, 8, 13, 1, 6, 11, 16, 4, 9, 14, 2, 7, 12
    };

    // Left rotation per gamma word: k*(k+1)/2 mod 32, k = PiIndex[i]
    localparam int PiRotate [CoreWords] = '{
        0, 15, 23, 24, 6, 4, 27, 1, 21, 2, 8, 10, 13, 9, 3, 28, 14
    };

    // Reverse the bytes of one word
    function automatic t_word swap_bytes(input t_word x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

@@ rtl/core/panama_core_step_unit.sv @@
// ----------------------------------------------------------------------------
// panama_core_step_unit: Panama keystream / hash core
// One Panama step per input transaction: push, pull, pull-emit or clear.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries an op and
//   eight words. Output channel (o_out_valid / i_out_ready / o_out_data)
//   carries one transaction per pull-emit step; other ops give none.
//   i_cfg_we / i_cfg_wdata write the byte-order bit; write it while idle.
//   Timing: an accepted transaction enters the input register and executes
//   from it, a pull-emit once the result register is free or being taken;
//   a pull-emit result is then held in the result register until taken.
//   Throughput: one transaction per cycle while no pull-emit waits on a
//   held result; the whole round is combinational from input register to state.
//   The 32-stage buffer is a shift line with fixed taps, so the buffer
//   rotation costs no memory port.
//   Reset clears state, buffer, byte order and both valid flags at once;
//   no clearing pass is needed.
//   When the receiver stalls, a held result stops the next pull-emit in the
//   input register and all behind it; push, pull and clear before it execute.
// ----------------------------------------------------------------------------
module panama_core_step_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pcs_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pcs_pkg::t_out_item  o_out_data
);

    logic                r_byte_order;
    logic                r_in_valid;
    pcs_pkg::t_in_item   r_in;
    logic                r_out_valid;
    pcs_pkg::t_out_item  r_out;
    pcs_pkg::t_out_item  n_out;
    pcs_pkg::t_core      r_core;
    pcs_pkg::t_core      n_core;
    pcs_pkg::t_core      round_core;
    pcs_pkg::t_stage     r_buf [pcs_pkg::BufferStages];
    pcs_pkg::t_stage     n_buf [pcs_pkg::BufferStages];

    pcs_pkg::t_stage     w;
    pcs_pkg::t_stage     data_in;
    pcs_pkg::t_stage     feed;
    pcs_pkg::t_stage     theta_in;
    pcs_pkg::t_word      emit_w [pcs_pkg::StageWords];
    logic                exec;
    logic                is_push;

    // Execute when the result slot is free or the op produces no result
    assign exec       = r_in_valid &&
                        ((r_in.op != pcs_pkg::OpEmit) || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || exec;
    assign is_push    = (r_in.op == pcs_pkg::OpPush);

    // Unpack input words, apply byte order and form the feed, theta and emitted words
    always_comb begin
        w[0] = r_in.in_word0;
        w[1] = r_in.in_word1;
        w[2] = r_in.in_word2;
        w[3] = r_in.in_word3;
        w[4] = r_in.in_word4;
        w[5] = r_in.in_word5;
        w[6] = r_in.in_word6;
        w[7] = r_in.in_word7;
        for (int i = 0; i < pcs_pkg::StageWords; i++) begin
            data_in[i] = r_byte_order ? pcs_pkg::swap_bytes(w[i]) : w[i];
            feed[i]     = is_push ? data_in[i] : r_core[i+1];
            theta_in[i] = is_push ? data_in[i] : r_buf[pcs_pkg::TapEarly][i];
            emit_w[i]   = w[i] ^ (r_byte_order ? pcs_pkg::swap_bytes(r_core[i+9])
                                               : r_core[i+9]);
        end
    end

    pcs_round u_round (
        .i_core     (r_core),
        .i_theta_in (theta_in),
        .i_late     (r_buf[pcs_pkg::TapLate]),
        .o_core     (round_core)
    );

    // Next state and buffer: shift one stage, write newest, mix into tap; clear zeroes all
    always_comb begin
        n_core = round_core;
        for (int k = 1; k < pcs_pkg::BufferStages; k++) begin
            n_buf[k] = r_buf[k-1];
        end
        for (int i = 0; i < pcs_pkg::StageWords; i++) begin
            n_buf[0][i] = feed[i] ^ r_buf[pcs_pkg::TapOldest][i];
            n_buf[pcs_pkg::TapMix][(i + 6) % pcs_pkg::StageWords] =
                r_buf[pcs_pkg::TapMix-1][(i + 6) % pcs_pkg::StageWords] ^
                r_buf[pcs_pkg::TapOldest][i];
        end
        if (r_in.op == pcs_pkg::OpClear) begin
            n_core = '0;
            for (int k = 0; k < pcs_pkg::BufferStages; k++) begin
                n_buf[k] = '0;
            end
        end
    end

    // Pack the emitted words
    always_comb begin
        n_out.out_word0 = emit_w[0];
        n_out.out_word1 = emit_w[1];
        n_out.out_word2 = emit_w[2];
        n_out.out_word3 = emit_w[3];
        n_out.out_word4 = emit_w[4];
        n_out.out_word5 = emit_w[5];
        n_out.out_word6 = emit_w[6];
        n_out.out_word7 = emit_w[7];
    end

    // Byte-order register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_order <= 1'b0;
        end else if (i_cfg_we) begin
            r_byte_order <= i_cfg_wdata;
        end
    end

    // Input register: take a transaction whenever the slot frees up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Core state and buffer: advance on execute
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core <= '0;
            for (int k = 0; k < pcs_pkg::BufferStages; k++) begin
                r_buf[k] <= '0;
            end
        end else if (exec) begin
            r_core <= n_core;
            for (int k = 0; k < pcs_pkg::BufferStages; k++) begin
                r_buf[k] <= n_buf[k];
            end
        end
    end

    // Result register: load on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec && (r_in.op == pcs_pkg::OpEmit)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec && (r_in.op == pcs_pkg::OpEmit)) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/core/pcs_round.sv @@
// ----------------------------------------------------------------------------
// pcs_round: one Panama state round
// Gamma, pi and theta over the 17-word state, then the buffer and
// theta inputs. Pure XOR, OR, NOT and fixed rotations.
// ----------------------------------------------------------------------------
module pcs_round (
    input  pcs_pkg::t_core  i_core,
    input  pcs_pkg::t_stage i_theta_in,
    input  pcs_pkg::t_stage i_late,
    output pcs_pkg::t_core  o_core
);

    pcs_pkg::t_word ax [pcs_pkg::CoreWords + 2];
    pcs_pkg::t_word g  [pcs_pkg::CoreWords];
    pcs_pkg::t_word gx [pcs_pkg::CoreWords + 4];

    // Gamma and pi: nonlinear mix, rotate, permute
    always_comb begin
        logic [63:0] dbl;
        pcs_pkg::t_word v;
        for (int m = 0; m < pcs_pkg::CoreWords; m++) begin
            ax[m] = i_core[m];
        end
        // Wrap the first words past the end of the state
        ax[pcs_pkg::CoreWords]     = i_core[0];
        ax[pcs_pkg::CoreWords + 1] = i_core[1];
        for (int i = 0; i < pcs_pkg::CoreWords; i++) begin
            g[i] = '0;
        end
        for (int i = 0; i < pcs_pkg::CoreWords; i++) begin
            v   = ax[i] ^ (ax[i+1] | ~ax[i+2]);
            dbl = {v, v} << pcs_pkg::PiRotate[i];
            g[pcs_pkg::PiIndex[i]] = dbl[63:32];
        end
    end

    // Theta, plus constant, buffer and data injection
    always_comb begin
        for (int m = 0; m < pcs_pkg::CoreWords; m++) begin
            gx[m] = g[m];
        end
        for (int m = 0; m < 4; m++) begin
            gx[pcs_pkg::CoreWords + m] = g[m];
        end
        o_core[0] = gx[0] ^ gx[1] ^ gx[4] ^ 32'd1;
        for (int i = 0; i < pcs_pkg::StageWords; i++) begin
            o_core[i+1] = gx[i+1] ^ gx[i+2] ^ gx[i+5] ^ i_theta_in[i];
            o_core[i+9] = gx[i+9] ^ gx[i+10] ^ gx[i+13] ^ i_late[i];
        end
    end

endmodule

@@ test/panama_core_step_unit_checker.sv @@
// ----------------------------------------------------------------------------
// panama_core_step_unit_checker: keystream scoreboard for the Panama core
// Watches the configuration port and both channels, runs its own copy of
// the Panama state and buffer for every accepted transaction, and compares
// each emitted block word by word with the oldest predicted block.
// ----------------------------------------------------------------------------
module panama_core_step_unit_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  pcs_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  pcs_pkg::t_out_item i_out_data,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_checked
);

    localparam int NumCore   = pcs_pkg::CoreWords;
    localparam int NumStage  = pcs_pkg::StageWords;
    localparam int NumBuffer = pcs_pkg::BufferStages;
    localparam int ReportMax = 10;

    // Shadow copy of the core: state words, stage ring, head and byte order
    pcs_pkg::t_word     state_q [NumCore];
    pcs_pkg::t_word     ring_q [NumBuffer][NumStage];
    int                 head_q;
    logic               swap_q;

    // Predicted emit blocks, oldest first
    pcs_pkg::t_out_item keystream_q [$];

    int errors_n  = 0;
    int checked_n = 0;
    int pending_n = 0;

    assign o_errors  = errors_n;
    assign o_pending = pending_n;
    assign o_checked = checked_n;

    // Word j of an input transaction (word 0 sits just below the op)
    function automatic pcs_pkg::t_word in_word(input pcs_pkg::t_in_item it, input int j);
        return it[255 - 32*j -: 32];
    endfunction

    function automatic pcs_pkg::t_word out_word(input pcs_pkg::t_out_item it, input int j);
        return it[255 - 32*j -: 32];
    endfunction

    // Apply the byte-order setting to one word
    function automatic pcs_pkg::t_word ordered(input pcs_pkg::t_word x);
        pcs_pkg::t_word y;
        int b;
        y = x;
        if (swap_q) begin
            for (b = 0; b < 4; b++) begin
                y[8*b +: 8] = x[31 - 8*b -: 8];
            end
        end
        return y;
    endfunction

    function automatic void wipe_state();
        int i;
        int s;
        for (i = 0; i < NumCore; i++) begin
            state_q[i] = '0;
        end
        for (s = 0; s < NumBuffer; s++) begin
            for (i = 0; i < NumStage; i++) begin
                ring_q[s][i] = '0;
            end
        end
        head_q = 0;
    endfunction

    // One Panama round: buffer update, gamma/pi/theta, then sigma
    function automatic void panama_round(input logic absorb, input pcs_pkg::t_stage blk);
        pcs_pkg::t_word  mix [NumCore];
        pcs_pkg::t_stage late;
        pcs_pkg::t_stage early;
        pcs_pkg::t_word  v;
        pcs_pkg::t_word  prior;
        int h;
        int i;
        int j;
        int k;
        int r;
        h = head_q;
        for (i = 0; i < NumStage; i++) begin
            late[i]  = ring_q[(h + 16) % NumBuffer][i];
            early[i] = ring_q[(h + 4) % NumBuffer][i];
        end
        // Step the ring back one stage and fold the oldest stage in
        h = (h + NumBuffer - 1) % NumBuffer;
        for (i = 0; i < NumStage; i++) begin
            prior = ring_q[h][i];
            ring_q[h][i] = (absorb ? blk[i] : state_q[i + 1]) ^ prior;
            ring_q[(h + 25) % NumBuffer][(i + 6) % NumStage] ^= prior;
        end
        // Nonlinear mix, word permutation and rotation
        for (i = 0; i < NumCore; i++) begin
            k = (5 * i) % NumCore;
            r = ((k * (k + 1)) / 2) % 32;
            v = state_q[i] ^ (state_q[(i + 1) % NumCore] | ~state_q[(i + 2) % NumCore]);
            mix[k] = (v << r) | (v >> (32 - r));
        end
        // Diffusion plus buffer or input injection
        state_q[0] = mix[0] ^ mix[1] ^ mix[4] ^ 32'd1;
        for (i = 0; i < NumStage; i++) begin
            j = i + 1;
            state_q[j] = mix[j] ^ mix[(j + 1) % NumCore] ^ mix[(j + 4) % NumCore] ^
                         (absorb ? blk[i] : early[i]);
        end
        for (i = 0; i < NumStage; i++) begin
            j = i + 9;
            state_q[j] = mix[j] ^ mix[(j + 1) % NumCore] ^ mix[(j + 4) % NumCore] ^ late[i];
        end
        head_q = h;
    endfunction

    // Advance the shadow core by one accepted step
    function automatic void predict_step(input pcs_pkg::t_in_item it);
        pcs_pkg::t_stage    blk;
        pcs_pkg::t_stage    fed;
        pcs_pkg::t_out_item blk_out;
        int i;
        for (i = 0; i < NumStage; i++) begin
            blk[i] = in_word(it, i);
            fed[i] = ordered(blk[i]);
        end
        case (it.op)
            pcs_pkg::OpPush: begin
                panama_round(1'b1, fed);
            end
            pcs_pkg::OpPull: begin
                panama_round(1'b0, blk);
            end
            pcs_pkg::OpEmit: begin
                for (i = 0; i < NumStage; i++) begin
                    blk_out[255 - 32*i -: 32] = blk[i] ^ ordered(state_q[i + 9]);
                end
                keystream_q.push_back(blk_out);
                panama_round(1'b0, blk);
            end
            pcs_pkg::OpClear: begin
                wipe_state();
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        pcs_pkg::t_out_item want;
        int i;
        if (!i_rst_n) begin
            wipe_state();
            swap_q = 1'b0;
            keystream_q.delete();
        end else begin
            if (i_cfg_we) begin
                swap_q = i_cfg_wdata;
            end
            // Compare an emitted block with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (keystream_q.size() == 0) begin
                    if (errors_n < ReportMax) begin
                        $display("unexpected output transaction: %h", i_out_data);
                    end
                    errors_n++;
                end else begin
                    want = keystream_q.pop_front();
                    checked_n++;
                    for (i = 0; i < NumStage; i++) begin
                        if (out_word(i_out_data, i) !== out_word(want, i)) begin
                            if (errors_n < ReportMax) begin
                                $display("out_word%0d of block %0d: expected %h, got %h",
                                         i, checked_n, out_word(want, i),
                                         out_word(i_out_data, i));
                            end
                            errors_n++;
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_step(i_in_data);
            end
        end
        pending_n = keystream_q.size();
    end

endmodule

@@ test/panama_core_step_unit_tb.sv @@
// ----------------------------------------------------------------------------
// panama_core_step_unit_tb: regression for the Panama core step unit
// Directed steps for every op in both byte orders (word extremes in the first),
// then random hash and keystream sessions mixed with noise, random idling
// on both channels, a long output stall and byte-order changes while idle.
// ----------------------------------------------------------------------------
module panama_core_step_unit_tb;

    localparam int CycleLimit  = 400000;
    localparam int ResultHold  = 400;
    localparam int DrainCycles = 8;
    localparam int IdlePercent = 36;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_wdata;
    logic               in_valid;
    logic               in_ready;
    pcs_pkg::t_in_item  in_data;
    logic               out_valid;
    logic               out_ready;
    pcs_pkg::t_out_item out_data;

    int errors;
    int pending;
    int checked;
    int cycle_n    = 0;
    int items_sent = 0;
    int op_count [4] = '{0, 0, 0, 0};
    bit calm        = 1'b0;
    bit hold_toggle = 1'b0;

    panama_core_step_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    panama_core_step_unit_checker checker_inst (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
    end

    always #2 clk = ~clk;

    // Watchdog
    always @(posedge clk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n >= CycleLimit) begin
            $display("panama_core_step_unit regression: fail");
            $finish;
        end
    end

    // Output side: random backpressure, plus a long hold on each toggle request
    initial begin
        int hold_left;
        bit hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_toggle != hold_seen) begin
                hold_seen = hold_toggle;
                hold_left = ResultHold;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= calm || ($urandom_range(99) >= IdlePercent);
            end
        end
    end

    function automatic pcs_pkg::t_in_item fill_item(input logic [1:0] op,
                                                    input pcs_pkg::t_word w);
        return {op, {8{w}}};
    endfunction

    function automatic pcs_pkg::t_in_item random_item(input logic [1:0] op);
        pcs_pkg::t_in_item it;
        int j;
        it.op = op;
        for (j = 0; j < 8; j++) begin
            it[255 - 32*j -: 32] = $urandom();
        end
        return it;
    endfunction

    // Offer one transaction, after a random gap, and hold it until accepted
    task automatic send_item(input pcs_pkg::t_in_item it);
        int gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(99) < IdlePercent) gap++;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        op_count[it.op]++;
        items_sent++;
        @(negedge clk);
    endtask

    // Stop offering, wait for every predicted block, then let the pipe empty
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    task automatic write_order(input logic swap);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= swap;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly well-formed sessions: clear, absorb, blank pulls, squeeze
    task automatic send_session();
        int  pushes;
        int  pulls;
        int  emits;
        bit  blank;
        if ($urandom_range(9) < 7) begin
            if ($urandom_range(3) != 0) begin
                send_item(random_item(pcs_pkg::OpClear));
            end
            pushes = $urandom_range(1, 6);
            repeat (pushes) send_item(random_item(pcs_pkg::OpPush));
            pulls = ($urandom_range(3) == 0) ? 32 : $urandom_range(0, 6);
            repeat (pulls) send_item(random_item(pcs_pkg::OpPull));
            emits = $urandom_range(1, 8);
            blank = 1'($urandom_range(1));
            repeat (emits) begin
                send_item(blank ? fill_item(pcs_pkg::OpEmit, '0)
                                : random_item(pcs_pkg::OpEmit));
            end
        end else begin
            repeat ($urandom_range(1, 8)) send_item(random_item(2'($urandom_range(3))));
        end
    endtask

    task automatic run_random(input int n);
        int target;
        target = items_sent + n;
        while (items_sent < target) send_session();
    endtask

    initial begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes of the words for each op, words as given
        write_order(1'b0);
        send_item(fill_item(pcs_pkg::OpEmit,  '0));
        send_item(fill_item(pcs_pkg::OpPush,  '0));
        send_item(fill_item(pcs_pkg::OpPush,  '1));
        send_item(fill_item(pcs_pkg::OpPush,  32'hAAAA_AAAA));
        send_item(fill_item(pcs_pkg::OpPull,  '1));
        send_item(fill_item(pcs_pkg::OpEmit,  '0));
        send_item(fill_item(pcs_pkg::OpEmit,  '1));
        send_item(fill_item(pcs_pkg::OpPull,  '0));
        send_item(fill_item(pcs_pkg::OpEmit,  32'h5555_5555));
        send_item(fill_item(pcs_pkg::OpClear, '1));
        send_item(fill_item(pcs_pkg::OpEmit,  '0));
        send_item(fill_item(pcs_pkg::OpClear, '0));
        send_item(fill_item(pcs_pkg::OpClear, '1));
        send_item(fill_item(pcs_pkg::OpPush,  32'h0123_4567));
        send_item(fill_item(pcs_pkg::OpEmit,  '0));

        // Directed: byte-reversed words
        write_order(1'b1);
        send_item(fill_item(pcs_pkg::OpPush,  32'h0123_4567));
        send_item(fill_item(pcs_pkg::OpPush,  '1));
        send_item(fill_item(pcs_pkg::OpPull,  32'h89AB_CDEF));
        send_item(fill_item(pcs_pkg::OpEmit,  '0));
        send_item(fill_item(pcs_pkg::OpEmit,  '1));
        send_item(fill_item(pcs_pkg::OpClear, '1));
        send_item(fill_item(pcs_pkg::OpEmit,  '0));
        send_item(fill_item(pcs_pkg::OpPush,  32'h89AB_CDEF));
        send_item(fill_item(pcs_pkg::OpEmit,  '0));

        // Random sessions, idling on both sides
        write_order(1'b0);
        run_random(400);

        // Back-to-back with no idling
        write_order(1'b1);
        calm <= 1'b1;
        run_random(250);
        calm <= 1'b0;

        // Long output stall while emits keep coming, then drain completely
        hold_toggle <= ~hold_toggle;
        repeat (60) begin
            send_item(random_item(($urandom_range(3) == 0) ? pcs_pkg::OpPush
                                                           : pcs_pkg::OpEmit));
        end
        settle();

        write_order(1'b0);
        run_random(350);
        write_order(1'b1);
        run_random(350);
        settle();

        $display("ran %0d transactions: %0d push, %0d pull, %0d emit, %0d clear",
                 items_sent, op_count[pcs_pkg::OpPush], op_count[pcs_pkg::OpPull],
                 op_count[pcs_pkg::OpEmit], op_count[pcs_pkg::OpClear]);
        $display("%0d output blocks compared over both byte orders, one %0d-cycle stall",
                 checked, ResultHold);
        if (errors == 0 && pending == 0) begin
            $display("panama_core_step_unit regression: pass");
        end else begin
            $display("panama_core_step_unit regression: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/pcs_pkg.sv
rtl/core/pcs_round.sv
rtl/core/panama_core_step_unit.sv
test/panama_core_step_unit_checker.sv
test/panama_core_step_unit_tb.sv
